>>> rtl/aflf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Adaptive lag filter package
// Shared widths, constants and transaction types for the adaptive
// first-order lag filter.
// ----------------------------------------------------------------------------
package aflf_pkg;

    // Sample width and derived widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int GAIN_WIDTH   = 9;
    localparam int BASE_WIDTH   = 8;
    localparam int RUN_WIDTH    = 6;
    // A weight (0..256) times a sample, plus headroom for the sum
    localparam int PROD_WIDTH   = SAMPLE_WIDTH + GAIN_WIDTH + 1;
    localparam int FRAC_BITS    = 8;

    // Adaptation constants
    localparam int BIG_STEP     = 8;
    localparam int RUN_LIMIT    = 30;
    localparam int GAIN_ONE     = 256;
    localparam int GAIN_BOOST   = 30;
    localparam int GAIN_LOW     = 3;
    localparam int STEP_SMALL   = 1;
    localparam int STEP_BIG     = 6;

    // Default depth of the queue between front and back
    localparam int CMD_DEPTH    = 4;

    // Input transaction
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] new_sample;
        logic signed [SAMPLE_WIDTH-1:0] previous_output;
        logic        [BASE_WIDTH-1:0]   base_gain;
        logic                           previous_direction;
    } in_t;

    // Result transaction
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] filtered_value;
        logic                           direction;
        logic        [GAIN_WIDTH-1:0]   gain_in_use;
    } out_t;

    // Work handed from the front to the back
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] new_sample;
        logic signed [SAMPLE_WIDTH-1:0] previous_output;
        logic        [GAIN_WIDTH-1:0]   gain;
        logic                           direction;
    } cmd_t;

endpackage : aflf_pkg
`default_nettype wire

>>> rtl/aflf_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based circular queue with occupancy count; full and empty are
// decoded from the count register.
// ----------------------------------------------------------------------------
module aflf_fifo
    import aflf_pkg::*;
#(
    parameter type T     = cmd_t,
    parameter int  DEPTH = CMD_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire T     wr_data,
    output logic      full,
    input  wire logic pop,
    output T          rd_data,
    output logic      empty
);

    localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
    localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

    T                     mem_reg [DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0] count_reg,  count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule : aflf_fifo
`default_nettype wire

>>> rtl/aflf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Adaptive lag filter front end
// Classifies each accepted sample (direction, step size), updates the run
// counter and the gain, and issues the blend command to the back end.
// ----------------------------------------------------------------------------
module aflf_front
    import aflf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  wire in_t  item,
    output cmd_t      cmd
);

    localparam logic signed [SAMPLE_WIDTH:0] BIG_POS = (SAMPLE_WIDTH + 1)'(BIG_STEP);
    localparam logic signed [SAMPLE_WIDTH:0] BIG_NEG = -BIG_POS;
    localparam logic [GAIN_WIDTH-1:0] GAIN_MAX   = GAIN_WIDTH'(GAIN_ONE);
    localparam logic [GAIN_WIDTH-1:0] GAIN_CEIL  = GAIN_WIDTH'(GAIN_ONE - GAIN_BOOST);
    localparam logic [GAIN_WIDTH-1:0] GAIN_ADD   = GAIN_WIDTH'(GAIN_BOOST);
    localparam logic [GAIN_WIDTH-1:0] GAIN_FLOOR = GAIN_WIDTH'(GAIN_LOW);
    localparam logic [RUN_WIDTH:0]    RUN_MAX    = (RUN_WIDTH + 1)'(RUN_LIMIT);
    localparam logic [RUN_WIDTH:0]    INC_SMALL  = (RUN_WIDTH + 1)'(STEP_SMALL);
    localparam logic [RUN_WIDTH:0]    INC_BIG    = (RUN_WIDTH + 1)'(STEP_BIG);

    logic [GAIN_WIDTH-1:0]    gain_reg, gain_next;
    logic [RUN_WIDTH-1:0]     run_reg,  run_next;
    logic                     dir_reg,  dir_next;
    logic signed [SAMPLE_WIDTH:0] diff;
    logic                     big_step;
    logic [RUN_WIDTH:0]       run_sum;
    logic [GAIN_WIDTH-1:0]    boost_sum;
    logic [GAIN_WIDTH-1:0]    gain_raised;

    // Difference and its classification
    assign diff     = {item.new_sample[SAMPLE_WIDTH-1], item.new_sample}
                    - {item.previous_output[SAMPLE_WIDTH-1], item.previous_output};
    assign big_step = (diff > BIG_POS) || (diff < BIG_NEG);

    // Candidate run count and raised gain
    assign run_sum     = {1'b0, run_reg} + (big_step ? INC_BIG : INC_SMALL);
    assign boost_sum   = {1'b0, item.base_gain} + GAIN_ADD;
    assign gain_raised = (boost_sum > GAIN_MAX) ? GAIN_MAX : boost_sum;

    // State update for one sample
    always_comb
    begin
        dir_next  = dir_reg;
        run_next  = run_reg;
        gain_next = gain_reg;
        if (diff > 0)
        begin
            dir_next = 1'b1;
        end
        else if (diff < 0)
        begin
            dir_next = 1'b0;
        end

        if (dir_next == item.previous_direction)
        begin
            if (run_sum > RUN_MAX)
            begin
                run_next = '0;
                if (gain_reg <= GAIN_CEIL)
                begin
                    gain_next = gain_raised;
                end
            end
            else
            begin
                run_next = run_sum[RUN_WIDTH-1:0];
            end
        end
        else
        begin
            run_next  = '0;
            gain_next = GAIN_FLOOR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
            run_reg  <= '0;
            dir_reg  <= 1'b0;
        end
        else if (accept)
        begin
            gain_reg <= gain_next;
            run_reg  <= run_next;
            dir_reg  <= dir_next;
        end
    end

    // Command for the back end
    always_comb
    begin
        cmd.new_sample      = item.new_sample;
        cmd.previous_output = item.previous_output;
        cmd.gain            = gain_next;
        cmd.direction       = dir_next;
    end

endmodule : aflf_front
`default_nettype wire

>>> rtl/aflf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Adaptive lag filter back end
// Two-stage blend: stage one forms both weighted products, stage two adds
// them, drops the fraction and holds the result until it is popped.
// ----------------------------------------------------------------------------
module aflf_back
    import aflf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t cmd,
    input  wire logic cmd_valid,
    output logic      cmd_pop,
    output out_t      result,
    output logic      empty,
    input  wire logic pop
);

    localparam logic [GAIN_WIDTH-1:0] GAIN_MAX = GAIN_WIDTH'(GAIN_ONE);

    logic signed [PROD_WIDTH-1:0] prod_old_reg, prod_old_next;
    logic signed [PROD_WIDTH-1:0] prod_new_reg, prod_new_next;
    logic [GAIN_WIDTH-1:0]        s1_gain_reg;
    logic                         s1_dir_reg;
    logic                         s1_valid_reg;
    out_t                         out_reg, out_next;
    logic                         out_valid_reg;
    logic                         out_adv;
    logic                         s1_adv;
    logic [GAIN_WIDTH-1:0]        weight_old;
    logic signed [PROD_WIDTH-1:0] weight_old_ext;
    logic signed [PROD_WIDTH-1:0] gain_ext;
    logic signed [PROD_WIDTH-1:0] prev_ext;
    logic signed [PROD_WIDTH-1:0] new_ext;
    logic signed [PROD_WIDTH-1:0] blend_sum;

    // Pipeline advance
    assign out_adv = !out_valid_reg || pop;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign cmd_pop = cmd_valid && s1_adv;

    // Stage one: weighted products, operands widened to the product width
    assign weight_old     = GAIN_MAX - cmd.gain;
    assign weight_old_ext = $signed({{(PROD_WIDTH - GAIN_WIDTH){1'b0}}, weight_old});
    assign gain_ext       = $signed({{(PROD_WIDTH - GAIN_WIDTH){1'b0}}, cmd.gain});
    assign prev_ext       = $signed({{(PROD_WIDTH - SAMPLE_WIDTH){cmd.previous_output[SAMPLE_WIDTH-1]}},
                                     cmd.previous_output});
    assign new_ext        = $signed({{(PROD_WIDTH - SAMPLE_WIDTH){cmd.new_sample[SAMPLE_WIDTH-1]}},
                                     cmd.new_sample});
    assign prod_old_next  = weight_old_ext * prev_ext;
    assign prod_new_next  = gain_ext * new_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            prod_old_reg <= prod_old_next;
            prod_new_reg <= prod_new_next;
            s1_gain_reg  <= cmd.gain;
            s1_dir_reg   <= cmd.direction;
        end
    end

    // Stage two: sum and floor shift
    assign blend_sum = prod_old_reg + prod_new_reg;

    always_comb
    begin
        out_next.filtered_value = blend_sum[FRAC_BITS +: SAMPLE_WIDTH];
        out_next.direction      = s1_dir_reg;
        out_next.gain_in_use    = s1_gain_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

endmodule : aflf_back
`default_nettype wire

>>> rtl/adaptive_first_order_lag_filter_unit.sv
`default_nettype none
// An accepted sample passes through the queue, the stage-one registers and the output register before its result shows.
// Throughput: one sample per cycle while the queue is not full; the gain and run-count update is a single
// compare-and-add step in the front end, the blend is a two-stage pipeline.
// Reset: asynchronous, active low; clears gain, run count, direction and queues.
// ----------------------------------------------------------------------------
// Adaptive first-order lag filter
// Front end updates the adaptive gain per sample, a short queue decouples it
// from the back end that blends previous and new sample with that gain.
// ----------------------------------------------------------------------------
module adaptive_first_order_lag_filter_unit
    import aflf_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire in_t  in_data,
    output logic      full,
    input  wire logic pop,
    output out_t      out_data,
    output logic      empty
);

    cmd_t cmd_in;
    cmd_t cmd_out;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;
    logic accept;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    // Classification and gain adaptation
    aflf_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .cmd    (cmd_in)
    );

    // Queue between front and back
    aflf_fifo #(
        .T     (cmd_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    // Weighted blend
    aflf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_valid (!cmd_empty),
        .cmd_pop   (cmd_pop),
        .result    (out_data),
        .empty     (empty),
        .pop       (pop)
    );

endmodule : adaptive_first_order_lag_filter_unit
`default_nettype wire
